[rtl/core/idbd_pkg.sv]
// shared types and constants for the interleaved delta byte decoder
package idbd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned INDEX_W = 10;

  localparam logic [COUNT_W-1:0] WPB_RESET = COUNT_W'(272);
  localparam int unsigned        MIN_WORDS = 2;

  // byte position within the coded stream
  typedef enum logic [1:0] {
    PH_HDR_HI  = 2'd0,
    PH_HDR_LO  = 2'd1,
    PH_LEAD    = 2'd2,
    PH_LONG_LO = 2'd3
  } idbd_phase_e;

  // one decoded word as it travels to the output register
  typedef struct packed {
    logic [WORD_W-1:0]  sample;
    logic [INDEX_W-1:0] sample_index;
    logic               last_of_block;
  } idbd_result_t;

endpackage

[rtl/core/idbd_in_stage.sv]
// input register stage holding one accepted byte
module idbd_in_stage (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [idbd_pkg::BYTE_W-1:0] in_byte_i,
  input  logic                       take_i,
  output logic                       valid_o,
  output logic [idbd_pkg::BYTE_W-1:0] byte_o
);
  import idbd_pkg::*;

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q;

  // free when empty or when the held byte is consumed this cycle
  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

[rtl/core/idbd_decode_core.sv]
// byte phase machine, channel history and single-pass delta reconstruction
module idbd_decode_core #(
  parameter int unsigned MAX_WORDS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [idbd_pkg::COUNT_W-1:0] words_per_block_i,
  input  logic                         step_i,
  input  logic [idbd_pkg::BYTE_W-1:0]  byte_i,
  output logic                         emit_o,
  output idbd_pkg::idbd_result_t       result_o
);
  import idbd_pkg::*;

  localparam int unsigned CapW = $clog2(MAX_WORDS + 1);
  localparam int unsigned CmpW = (CapW > COUNT_W + 1) ? CapW : COUNT_W + 1;
  localparam logic [CmpW-1:0] MaxCnt = CmpW'(MAX_WORDS);
  localparam logic [CmpW-1:0] MinCnt = CmpW'(MIN_WORDS);

  idbd_phase_e        phase_q, phase_d;
  logic [WORD_W-1:0]  older_q, older_d;
  logic [WORD_W-1:0]  newer_q, newer_d;
  logic [COUNT_W-1:0] counter_q, counter_d;
  logic [BYTE_W-1:0]  held_q, held_d;

  logic [CmpW-1:0]    wpb_ext;
  logic [CmpW-1:0]    count_eff;
  logic [CmpW-1:0]    idx_plus;
  logic               last;
  logic               emit;
  logic [WORD_W-1:0]  delta;
  logic [WORD_W-1:0]  word;

  // clamp the block length into the supported window
  assign wpb_ext   = CmpW'(words_per_block_i);
  always_comb begin
    count_eff = wpb_ext;
    if (wpb_ext < MinCnt) begin
      count_eff = MinCnt;
    end
    if (count_eff > MaxCnt) begin
      count_eff = MaxCnt;
    end
  end

  assign idx_plus = CmpW'(counter_q) + CmpW'(1);
  assign last     = idx_plus >= count_eff;

  // next state
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      unique case (phase_q) inside
        PH_HDR_HI: begin
          phase_d = PH_HDR_LO;
        end
        PH_LEAD: begin
          if (byte_i[7]) begin
            phase_d = PH_LONG_LO;
          end else if (last || idx_plus < MinCnt) begin
            phase_d = PH_HDR_HI;
          end else begin
            phase_d = PH_LEAD;
          end
        end
        PH_HDR_LO, PH_LONG_LO: begin
          if (last || idx_plus < MinCnt) begin
            phase_d = PH_HDR_HI;
          end else begin
            phase_d = PH_LEAD;
          end
        end
        default: begin
          phase_d = PH_HDR_HI;
        end
      endcase
    end
  end

  // datapath and outputs
  always_comb begin
    emit  = 1'b0;
    delta = '0;
    word  = '0;
    held_d = held_q;
    unique case (phase_q)
      PH_HDR_HI: begin
        held_d = byte_i;
      end
      PH_HDR_LO: begin
        emit = 1'b1;
        word = {held_q, byte_i};
      end
      PH_LEAD: begin
        if (byte_i[7]) begin
          held_d = byte_i;
        end else begin
          emit  = 1'b1;
          delta = {{(WORD_W - 7){byte_i[6]}}, byte_i[6:0]};
          word  = older_q + delta;
        end
      end
      PH_LONG_LO: begin
        emit  = 1'b1;
        delta = {held_q[6], held_q[6:0], byte_i};
        word  = older_q + delta;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_comb begin
    older_d   = older_q;
    newer_d   = newer_q;
    counter_d = counter_q;
    if (step_i && emit) begin
      older_d   = newer_q;
      newer_d   = word;
      counter_d = last ? '0 : idx_plus[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR_HI;
      older_q   <= '0;
      newer_q   <= '0;
      counter_q <= '0;
      held_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      older_q   <= older_d;
      newer_q   <= newer_d;
      counter_q <= counter_d;
      if (step_i) begin
        held_q <= held_d;
      end
    end
  end

  assign emit_o                 = step_i && emit;
  assign result_o.sample        = word;
  assign result_o.sample_index  = counter_q[INDEX_W-1:0];
  assign result_o.last_of_block = last;

`ifndef NO_ASSERTIONS
  a_last_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && emit && last) |=> (counter_q == '0 && phase_q == PH_HDR_HI))
    else $error("block end did not rewind to header");

  a_delta_after_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LEAD || phase_q == PH_LONG_LO) |-> (counter_q >= COUNT_W'(MIN_WORDS)))
    else $error("delta phase reached before both header words");
`endif

endmodule

[rtl/core/idbd_out_stage.sv]
// output register holding one decoded word until the consumer takes it
module idbd_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  idbd_pkg::idbd_result_t result_i,
  output logic                   space_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output idbd_pkg::idbd_result_t result_o
);
  import idbd_pkg::*;

  logic         valid_q, valid_d;
  idbd_result_t result_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

[rtl/core/interleaved_delta_byte_decoder_top.sv]
// top level of the interleaved delta byte decoder
// a decoded word passes from the input register through the decode core into the output register
// throughput: one byte per cycle; header high bytes and long delta lead bytes give no output
// the input register is freed whenever the output register is empty or being drained
// reset (rst_ni low, asynchronous): empty pipeline, zeroed history and counter,
// header phase, words_per_block back to 272
module interleaved_delta_byte_decoder_top #(
  parameter int unsigned MAX_WORDS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // compressed byte stream
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [idbd_pkg::BYTE_W-1:0]        in_byte_i,
  // decoded words
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [idbd_pkg::WORD_W-1:0] sample_o,
  output logic [idbd_pkg::INDEX_W-1:0]       sample_index_o,
  output logic                               last_of_block_o,
  // block length register write
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [idbd_pkg::COUNT_W-1:0]       words_per_block_i
);
  import idbd_pkg::*;

  logic [COUNT_W-1:0] wpb_q, wpb_d;

  logic              byte_valid;
  logic [BYTE_W-1:0] byte_held;
  logic              out_space;
  logic              step;
  logic              emit;
  idbd_result_t      dec_result;
  idbd_result_t      out_result;

  // configuration register, written in a single transaction at any time
  assign cfg_ready_o = 1'b1;
  assign wpb_d       = (cfg_valid_i && cfg_ready_o) ? words_per_block_i : wpb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpb_q <= WPB_RESET;
    end else begin
      wpb_q <= wpb_d;
    end
  end

  // stage one: accepted byte waits here for the decoder
  idbd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .take_i     (step),
    .valid_o    (byte_valid),
    .byte_o     (byte_held)
  );

  // a byte is decoded when the output register can absorb any word it yields;
  // bytes that yield nothing still wait so the decode order stays simple
  assign step = byte_valid && out_space;

  // decode: phase machine plus one 16-bit add against the same channel's history
  idbd_decode_core #(
    .MAX_WORDS (MAX_WORDS)
  ) u_decode (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .words_per_block_i (wpb_q),
    .step_i            (step),
    .byte_i            (byte_held),
    .emit_o            (emit),
    .result_o          (dec_result)
  );

  // stage two: result register toward the consumer
  idbd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .result_i    (dec_result),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign sample_o        = $signed(out_result.sample);
  assign sample_index_o  = out_result.sample_index;
  assign last_of_block_o = out_result.last_of_block;

`ifndef NO_ASSERTIONS
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (byte_valid && out_valid_o && !out_ready_i))
    else $error("input stalled without a blocked output");

  a_emit_needs_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o)
    else $error("decoded word not presented");
`endif

endmodule
